/* rtl/c_subset_token_scanner_defines.svh */
// assertion macros shared by the token scanner modules
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef C_SUBSET_TOKEN_SCANNER_DEFINES_SVH
`define C_SUBSET_TOKEN_SCANNER_DEFINES_SVH

// property must hold on every clock edge out of reset
`define CTS_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define CTS_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CTS_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cts_pkg.sv */
// types, kind codes and lookup functions of the token scanner
// no dependencies
`default_nettype none

package cts_pkg;

	typedef struct packed {
		logic       action;
		logic [7:0] char_byte;
	} item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] line_number;
		logic [9:0]  start_column;
		logic [10:0] token_length;
		logic [7:0]  char_value;
		logic        last_of_run;
	} result_t;

	// records handed from the scanner to the result queue in one cycle
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef enum logic [6:0] {
		M_IDLE   = 7'b0000001,
		M_NUM    = 7'b0000010,
		M_IDENT  = 7'b0000100,
		M_OP     = 7'b0001000,
		M_CHV    = 7'b0010000,
		M_CHSKIP = 7'b0100000,
		M_STR    = 7'b1000000
	} mode_t;

	localparam logic       ACT_CHAR = 1'b0;
	localparam logic       ACT_EOL  = 1'b1;

	localparam logic [5:0] K_IDENT = 6'd0;
	localparam logic [5:0] K_NUM   = 6'd1;
	localparam logic [5:0] K_CHAR  = 6'd2;
	localparam logic [5:0] K_STR   = 6'd3;
	localparam logic [5:0] K_KW0   = 6'd4;
	localparam logic [5:0] K_PLUS  = 6'd19;
	localparam logic [5:0] K_MINUS = 6'd20;
	localparam logic [5:0] K_MUL   = 6'd21;
	localparam logic [5:0] K_DIV   = 6'd22;
	localparam logic [5:0] K_LSS   = 6'd23;
	localparam logic [5:0] K_NEQ   = 6'd29;
	localparam logic [5:0] K_COLON = 6'd30;
	localparam logic [5:0] K_SEMI  = 6'd31;
	localparam logic [5:0] K_COMMA = 6'd32;
	localparam logic [5:0] K_LPAR  = 6'd33;
	localparam logic [5:0] K_RPAR  = 6'd34;
	localparam logic [5:0] K_LBRK  = 6'd35;
	localparam logic [5:0] K_RBRK  = 6'd36;
	localparam logic [5:0] K_LBRC  = 6'd37;
	localparam logic [5:0] K_RBRC  = 6'd38;
	localparam logic [5:0] K_ERR   = 6'd39;

	localparam logic [1:0] P_LT  = 2'd0;
	localparam logic [1:0] P_GT  = 2'd1;
	localparam logic [1:0] P_EQ  = 2'd2;
	localparam logic [1:0] P_NOT = 2'd3;

	localparam int KW_COUNT = 15;
	localparam int QDEPTH   = 4;
	localparam int QAW      = 2;

	localparam logic [55:0] KW_PAT [KW_COUNT] = '{
		56'("const"), 56'("int"), 56'("char"), 56'("void"), 56'("main"),
		56'("if"), 56'("else"), 56'("switch"), 56'("case"), 56'("default"),
		56'("while"), 56'("for"), 56'("scanf"), 56'("printf"), 56'("return")
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd6,
		3'd4, 3'd7, 3'd5, 3'd3, 3'd5, 3'd6, 3'd6
	};

	// window holds the last seven lowercased characters, len is at most seven
	function automatic logic [5:0] ident_kind(input logic [55:0] win, input logic [2:0] len);
		logic [5:0] k;
		k = K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (len == KW_LEN[i] && win == KW_PAT[i])
				k = K_KW0 + 6'(i);
		end
		return k;
	endfunction

	// one-character operator: valid bit and kind
	function automatic logic [6:0] op_kind(input logic [7:0] c);
		logic [6:0] r;
		case (c)
			8'h2B: r = {1'b1, K_PLUS};
			8'h2D: r = {1'b1, K_MINUS};
			8'h2A: r = {1'b1, K_MUL};
			8'h2F: r = {1'b1, K_DIV};
			8'h3A: r = {1'b1, K_COLON};
			8'h3B: r = {1'b1, K_SEMI};
			8'h2C: r = {1'b1, K_COMMA};
			8'h28: r = {1'b1, K_LPAR};
			8'h29: r = {1'b1, K_RPAR};
			8'h5B: r = {1'b1, K_LBRK};
			8'h5D: r = {1'b1, K_RBRK};
			8'h7B: r = {1'b1, K_LBRC};
			8'h7D: r = {1'b1, K_RBRC};
			default: r = {1'b0, K_IDENT};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/cts_front.sv */
// scanner front end: line/column tracking, token state machine, record building
// depends on cts_pkg and c_subset_token_scanner_defines.svh
`default_nettype none
`include "c_subset_token_scanner_defines.svh"

module cts_front #(
	parameter int MAX_LINE_CHARS = 1024
) (
	input  wire               clk,
	input  wire               arst_n,
	input  cts_pkg::item_t    item,
	input  wire               accept,
	output cts_pkg::push_t    wr
);

	localparam int CW = $clog2(MAX_LINE_CHARS);
	localparam int TW = $clog2(MAX_LINE_CHARS + 1);

	cts_pkg::mode_t mode_q, mode_d;
	logic [1:0]     pend_q, pend_d;
	logic [CW-1:0]  ts_q, ts_d, col_q, col_d;
	logic [15:0]    line_q, line_d;
	logic [55:0]    win_q, win_d;
	logic [TW-1:0]  tc_q, tc_d;
	logic           halted_q, halted_d;

	logic [7:0]  c, lc;
	logic        dig, let_c;
	logic [6:0]  opk;
	logic        fl_v, st_v, d_v, do_flush, do_start;
	cts_pkg::result_t fl_r, st_r, d_r;

	function automatic cts_pkg::result_t mk(input logic [5:0] k, input logic [15:0] ln,
		input logic [CW-1:0] col, input logic [TW-1:0] len, input logic [7:0] cv);
		cts_pkg::result_t r;
		r.token_kind   = k;
		r.line_number  = ln;
		r.start_column = 10'(col);
		r.token_length = 11'(len);
		r.char_value   = cv;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	assign c     = item.char_byte;
	assign lc    = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	assign dig   = (c >= 8'h30 && c <= 8'h39);
	assign let_c = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
	assign opk   = cts_pkg::op_kind(c);

	// record of the open token, if any
	always_comb begin
		fl_v = 1'b0;
		fl_r = mk(cts_pkg::K_NUM, line_q, ts_q, tc_q, 8'd0);
		case (mode_q)
			cts_pkg::M_NUM: fl_v = 1'b1;
			cts_pkg::M_IDENT: begin
				fl_v = 1'b1;
				fl_r.token_kind = (tc_q <= TW'(7)) ? cts_pkg::ident_kind(win_q, tc_q[2:0])
				                                   : cts_pkg::K_IDENT;
			end
			cts_pkg::M_OP: begin
				fl_v = (pend_q != cts_pkg::P_NOT);
				fl_r.token_kind   = cts_pkg::K_LSS + {3'd0, pend_q, 1'b0};
				fl_r.token_length = 11'd1;
			end
			default: fl_v = 1'b0;
		endcase
	end

	always_comb begin
		mode_d = mode_q; pend_d = pend_q; ts_d = ts_q; col_d = col_q; line_d = line_q;
		win_d = win_q; tc_d = tc_q; halted_d = halted_q;
		d_v = 1'b0; d_r = mk(cts_pkg::K_CHAR, line_q, ts_q, TW'(1), 8'd0);
		do_flush = 1'b0; do_start = 1'b0;
		if (accept && !halted_q) begin
			if (item.action == cts_pkg::ACT_EOL) begin
				if (mode_q == cts_pkg::M_CHV) begin
					d_v = 1'b1;
				end else if (mode_q == cts_pkg::M_STR) begin
					d_v = 1'b1;
					d_r = mk(cts_pkg::K_ERR, line_q, ts_q, tc_q, 8'd0);
					halted_d = 1'b1;
				end else if (mode_q != cts_pkg::M_CHSKIP) begin
					do_flush = 1'b1;
				end
				mode_d = cts_pkg::M_IDLE;
				col_d  = '0;
				if (line_q != 16'hFFFF) line_d = line_q + 16'd1;
			end else begin
				case (mode_q)
					cts_pkg::M_NUM: begin
						if (dig) begin
							win_d = {win_q[47:0], lc};
							if (tc_q != TW'(MAX_LINE_CHARS)) tc_d = tc_q + TW'(1);
						end else begin
							do_flush = 1'b1; do_start = 1'b1;
						end
					end
					cts_pkg::M_IDENT: begin
						if (dig || let_c) begin
							win_d = {win_q[47:0], lc};
							if (tc_q != TW'(MAX_LINE_CHARS)) tc_d = tc_q + TW'(1);
						end else begin
							do_flush = 1'b1; do_start = 1'b1;
						end
					end
					cts_pkg::M_OP: begin
						if (c == 8'h3D) begin
							d_v = 1'b1;
							d_r = mk((pend_q == cts_pkg::P_NOT) ? cts_pkg::K_NEQ
								: cts_pkg::K_LSS + {3'd0, pend_q, 1'b1},
								line_q, ts_q, TW'(2), 8'd0);
							mode_d = cts_pkg::M_IDLE;
						end else begin
							do_flush = 1'b1; do_start = 1'b1;
						end
					end
					cts_pkg::M_CHV: begin
						d_v = 1'b1;
						d_r.char_value = c;
						mode_d = cts_pkg::M_CHSKIP;
					end
					cts_pkg::M_CHSKIP: mode_d = cts_pkg::M_IDLE;
					cts_pkg::M_STR: begin
						if (c == 8'h22) begin
							d_v = 1'b1;
							d_r = mk(cts_pkg::K_STR, line_q, ts_q, tc_q, 8'd0);
							mode_d = cts_pkg::M_IDLE;
						end else if (tc_q != TW'(MAX_LINE_CHARS)) begin
							tc_d = tc_q + TW'(1);
						end
					end
					default: do_start = 1'b1;
				endcase
				if (col_q != CW'(MAX_LINE_CHARS - 1)) col_d = col_q + CW'(1);
			end
			if (do_flush) mode_d = cts_pkg::M_IDLE;
			// a new token begins at this character
			if (do_start) begin
				ts_d = col_q; tc_d = '0; win_d = '0;
				if (dig || let_c) begin
					mode_d = dig ? cts_pkg::M_NUM : cts_pkg::M_IDENT;
					win_d  = {48'd0, lc};
					tc_d   = TW'(1);
				end else begin
					case (c)
						8'h3C: begin mode_d = cts_pkg::M_OP; pend_d = cts_pkg::P_LT; end
						8'h3E: begin mode_d = cts_pkg::M_OP; pend_d = cts_pkg::P_GT; end
						8'h3D: begin mode_d = cts_pkg::M_OP; pend_d = cts_pkg::P_EQ; end
						8'h21: begin mode_d = cts_pkg::M_OP; pend_d = cts_pkg::P_NOT; end
						8'h27: mode_d = cts_pkg::M_CHV;
						8'h22: mode_d = cts_pkg::M_STR;
						default: mode_d = cts_pkg::M_IDLE;
					endcase
				end
			end
		end
	end

	assign st_v = do_start && opk[6];
	always_comb begin
		st_r = mk(opk[5:0], line_q, col_q, TW'(1), 8'd0);
		st_r.last_of_run = 1'b1;
	end

	always_comb begin
		wr.n  = {1'b0, d_v} + {1'b0, do_flush && fl_v} + {1'b0, st_v};
		wr.r0 = d_v ? d_r : ((do_flush && fl_v) ? fl_r : st_r);
		wr.r0.last_of_run = (wr.n == 2'd1);
		wr.r1 = st_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= cts_pkg::M_IDLE;
			pend_q   <= '0;
			ts_q     <= '0;
			col_q    <= '0;
			line_q   <= '0;
			win_q    <= '0;
			tc_q     <= '0;
			halted_q <= 1'b0;
		end else begin
			mode_q   <= mode_d;
			pend_q   <= pend_d;
			ts_q     <= ts_d;
			col_q    <= col_d;
			line_q   <= line_d;
			win_q    <= win_d;
			tc_q     <= tc_d;
			halted_q <= halted_d;
		end
	end

	`CTS_NEXT(a_halt_sticky, halted_q, halted_q, "halt released without reset")
	`CTS_IMPLY(a_halt_silent, halted_q, wr.n == 2'd0, "records emitted while halted")
	`CTS_IMPLY(a_pair_last, wr.n == 2'd2, wr.r1.last_of_run && !wr.r0.last_of_run,
		"bad last marking on record pair")

endmodule

`default_nettype wire

/* rtl/cts_back.sv */
// result queue: takes up to two records a cycle, hands out one record per pop
// depends on cts_pkg and c_subset_token_scanner_defines.svh
`default_nettype none
`include "c_subset_token_scanner_defines.svh"

module cts_back (
	input  wire                clk,
	input  wire                arst_n,
	input  cts_pkg::push_t     wr,
	input  wire                pop,
	output logic               empty,
	output logic               full,
	output cts_pkg::result_t   result
);

	cts_pkg::result_t          mem_q [cts_pkg::QDEPTH];
	logic [cts_pkg::QAW-1:0]   wp_q, rp_q;
	logic [cts_pkg::QAW:0]     cnt_q;
	logic                      rd;

	assign empty  = (cnt_q == '0);
	// need room for two records before the next word is taken
	assign full   = (cnt_q > (cts_pkg::QAW+1)'(cts_pkg::QDEPTH - 2));
	assign result = mem_q[rp_q];
	assign rd     = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr.n != 2'd0) mem_q[wp_q] <= wr.r0;
		if (wr.n == 2'd2) mem_q[wp_q + 1'b1] <= wr.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + cts_pkg::QAW'(wr.n);
			rp_q  <= rp_q + cts_pkg::QAW'(rd);
			cnt_q <= cnt_q + (cts_pkg::QAW+1)'(wr.n) - (cts_pkg::QAW+1)'(rd);
		end
	end

	`CTS_CHECK(a_cnt_range, cnt_q <= (cts_pkg::QAW+1)'(cts_pkg::QDEPTH), "queue overflow")
	`CTS_IMPLY(a_room, wr.n != 2'd0, cnt_q <= (cts_pkg::QAW+1)'(cts_pkg::QDEPTH - 2),
		"write without room for two records")
	`CTS_NEXT(a_drain, rd && wr.n == 2'd0, cnt_q == $past(cnt_q) - 1'b1,
		"pop did not shrink the queue")

endmodule

`default_nettype wire

/* rtl/c_subset_token_scanner.sv */
// C-subset token scanner. Each accepted word (a source byte or an end of line)
// goes through the scanner front end in the cycle it is pushed, so one word can be
// pushed every clock. A word yields zero, one or two token records. They land in a
// four-entry result queue and leave one per pop. full rises once three records are
// waiting, which leaves fewer than two entries free. With a consumer popping every
// cycle, a one-record word leaves the fill level unchanged and a two-record word
// raises it by one. The input stalls only after two-record words have outnumbered
// zero-record words enough to fill three entries, and then only until one pop
// frees an entry. When the queue was empty, a record is visible on the result port
// in the cycle after its word is pushed. After an unterminated string the block
// emits an error record and ignores input until reset.
// depends on cts_pkg, cts_front, cts_back
`default_nettype none

module c_subset_token_scanner #(
	parameter int MAX_LINE_CHARS = 1024
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  cts_pkg::item_t     item,
	input  wire                pop,
	output logic               empty,
	output cts_pkg::result_t   result
);

	cts_pkg::push_t wr;
	logic           accept;

	assign accept = push && !full;

	cts_front #(
		.MAX_LINE_CHARS(MAX_LINE_CHARS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.accept (accept),
		.wr     (wr)
	);

	cts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.empty  (empty),
		.full   (full),
		.result (result)
	);

endmodule

`default_nettype wire
